[sv/audio_block_ring_checksum_sink_core_defines.svh]
// Assertion shorthands for the checker file.
`ifndef AUDIO_BLOCK_RING_CHECKSUM_SINK_CORE_DEFINES_SVH
`define AUDIO_BLOCK_RING_CHECKSUM_SINK_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ABRCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ABRCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[sv/abrcs_pkg.sv]
package abrcs_pkg;

  // Request codes
  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_COMMIT = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_BLOCKS = 2'd0;
  localparam logic [1:0] CFG_FRAMES = 2'd1;
  localparam logic [1:0] CFG_DRAIN  = 2'd2;

  localparam logic [3:0] BLOCKS_RESET = 4'd4;
  localparam logic [8:0] FRAMES_RESET = 9'd64;

  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;

  // Samples in one block: twice the frame count, frame count held in 9 bits
  localparam int SAMPLES_W = 10;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [8:0]          sample_offset;
    logic signed [15:0]  sample_value;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic        ring_full;
    logic [3:0]  queued_blocks;
    logic [31:0] underrun_count;
    logic [31:0] running_hash;
    logic [31:0] blocks_played;
  } out_t;

  typedef struct packed {
    logic                 start;
    logic [SAMPLES_W-1:0] count;
  } hash_ctl_t;

endpackage

[sv/audio_block_ring_checksum_sink_core.sv]
// Ring of stereo sample blocks with an FNV-1a 32 checksum on the consumer side. A request is
// taken when start is high and busy is low; its result appears on res_o for exactly one cycle
// with done_o high and cannot be held off, so the receiver must take it then. Sample writes,
// commits and ticks on an empty ring give their result in the cycle after the request and the
// next request may follow straight away. A tick that consumes a block keeps busy high while
// the single fold unit reads the block one sample per cycle from the store: the result comes
// once the last sample of the block has been folded in. After reset the store is zeroed one
// word a cycle, all BLOCK_CAPACITY*2*MAX_FRAMES words, with busy high; configuration
// writes are taken throughout. Write configuration only while no request is outstanding.
module audio_block_ring_checksum_sink_core #(
  parameter int BLOCK_CAPACITY = 8,
  parameter int MAX_FRAMES     = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  abrcs_pkg::in_t     req_i,
  output logic               done_o,
  output abrcs_pkg::out_t    res_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [8:0]         cfg_wdata_i
);

  localparam int STRIDE  = 2 * MAX_FRAMES;
  localparam int DEPTH   = BLOCK_CAPACITY * STRIDE;
  localparam int AW      = $clog2(DEPTH);
  localparam int MF_CLIP = (MAX_FRAMES > 511) ? 511 : MAX_FRAMES;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_HASH  = 2'd2;

  localparam logic [6:0]    CAP7      = 7'(BLOCK_CAPACITY);
  localparam logic [8:0]    FR_MAX    = 9'(MF_CLIP);
  localparam logic [AW-1:0] CLR_LAST  = AW'(DEPTH - 1);
  localparam logic [AW-1:0] STRIDE_AW = AW'(STRIDE);

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic [3:0]    blocks_cfg_q, blocks_cfg_d;
  logic [8:0]    frames_cfg_q, frames_cfg_d;
  logic          drain_q, drain_d;
  logic [3:0]    wb_q, wb_d;
  logic [3:0]    rb_q, rb_d;
  logic [3:0]    qd_q, qd_d;
  logic [31:0]   played_q, played_d;
  logic [31:0]   und_q, und_d;
  logic          acc_q, acc_d;
  logic          done_q, done_d;

  logic [3:0]                      nb;
  logic [8:0]                      frames_eff;
  logic [abrcs_pkg::SAMPLES_W-1:0] samples;
  logic                            full;
  logic                            off_ok;
  logic [AW-1:0]                   wr_addr;
  logic [AW-1:0]                   rd_base;
  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [15:0]                     ram_wdata;
  logic                            ram_re;
  logic [AW-1:0]                   ram_raddr;
  logic [15:0]                     ram_rdata;
  abrcs_pkg::hash_ctl_t            hctl;
  logic                            hash_done;
  logic [31:0]                     hash_val;

  // Clamp geometry registers to the legal range
  always_comb begin
    if (blocks_cfg_q == 4'd0) begin
      nb = 4'd1;
    end else if ({3'd0, blocks_cfg_q} > CAP7) begin
      nb = CAP7[3:0];
    end else begin
      nb = blocks_cfg_q;
    end
    if (frames_cfg_q == 9'd0) begin
      frames_eff = 9'd1;
    end else if (frames_cfg_q > FR_MAX) begin
      frames_eff = FR_MAX;
    end else begin
      frames_eff = frames_cfg_q;
    end
  end

  assign samples = {frames_eff, 1'b0};
  assign full    = qd_q >= nb;
  assign off_ok  = {1'b0, req_i.sample_offset} < samples;
  assign wr_addr = AW'(wb_q) * STRIDE_AW + AW'(req_i.sample_offset);
  assign rd_base = AW'(rb_q) * STRIDE_AW;
  assign busy    = state_q != ST_IDLE;

  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    blocks_cfg_d = blocks_cfg_q;
    frames_cfg_d = frames_cfg_q;
    drain_d      = drain_q;
    wb_d         = wb_q;
    rb_d         = rb_q;
    qd_d         = qd_q;
    played_d     = played_q;
    und_d        = und_q;
    acc_d        = 1'b0;
    done_d       = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = wr_addr;
    ram_wdata    = 16'(req_i.sample_value);
    hctl.start   = 1'b0;
    hctl.count   = samples;

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          done_d = 1'b1;
          case (req_i.req_type)
            abrcs_pkg::REQ_WRITE: begin
              if (!full && off_ok) begin
                ram_we = 1'b1;
                acc_d  = 1'b1;
              end
            end
            abrcs_pkg::REQ_COMMIT: begin
              if (!full) begin
                wb_d  = (wb_q + 4'd1 == nb) ? 4'd0 : wb_q + 4'd1;
                qd_d  = qd_q + 4'd1;
                acc_d = 1'b1;
              end
            end
            abrcs_pkg::REQ_TICK: begin
              if (qd_q == 4'd0) begin
                und_d = und_q + 32'd1;
              end else begin
                // hold the result until the block has been folded in
                done_d     = 1'b0;
                hctl.start = 1'b1;
                state_d    = ST_HASH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          rb_d     = (rb_q + 4'd1 == nb) ? 4'd0 : rb_q + 4'd1;
          qd_d     = qd_q - 4'd1;
          played_d = played_q + 32'd1;
          if (drain_q && qd_q == 4'd1) begin
            und_d = und_q + 32'd1;
          end
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      case (cfg_idx_i)
        abrcs_pkg::CFG_BLOCKS: begin
          blocks_cfg_d = cfg_wdata_i[3:0];
          wb_d = 4'd0;
          rb_d = 4'd0;
          qd_d = 4'd0;
        end
        abrcs_pkg::CFG_FRAMES: begin
          frames_cfg_d = cfg_wdata_i;
          wb_d = 4'd0;
          rb_d = 4'd0;
          qd_d = 4'd0;
        end
        abrcs_pkg::CFG_DRAIN: begin
          drain_d = cfg_wdata_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_cnt_q    <= '0;
      blocks_cfg_q <= abrcs_pkg::BLOCKS_RESET;
      frames_cfg_q <= abrcs_pkg::FRAMES_RESET;
      drain_q      <= 1'b0;
      wb_q         <= 4'd0;
      rb_q         <= 4'd0;
      qd_q         <= 4'd0;
      played_q     <= 32'd0;
      und_q        <= 32'd0;
      acc_q        <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_cnt_q    <= clr_cnt_d;
      blocks_cfg_q <= blocks_cfg_d;
      frames_cfg_q <= frames_cfg_d;
      drain_q      <= drain_d;
      wb_q         <= wb_d;
      rb_q         <= rb_d;
      qd_q         <= qd_d;
      played_q     <= played_d;
      und_q        <= und_d;
      acc_q        <= acc_d;
      done_q       <= done_d;
    end
  end

  abrcs_ram #(
    .W (16),
    .D (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  abrcs_hash #(
    .AW (AW)
  ) u_hash (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (hctl),
    .base_i    (rd_base),
    .rd_en_o   (ram_re),
    .rd_addr_o (ram_raddr),
    .rd_data_i (ram_rdata),
    .hash_o    (hash_val),
    .done_o    (hash_done)
  );

  assign done_o               = done_q;
  assign res_o.accepted       = acc_q;
  assign res_o.ring_full      = full;
  assign res_o.queued_blocks  = qd_q;
  assign res_o.underrun_count = und_q;
  assign res_o.running_hash   = hash_val;
  assign res_o.blocks_played  = played_q;

endmodule

[sv/abrcs_ram.sv]
module abrcs_ram #(
  parameter int W = 16,
  parameter int D = 4096
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic                 re_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/abrcs_hash.sv]
module abrcs_hash #(
  parameter int AW = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  abrcs_pkg::hash_ctl_t  ctl_i,
  input  logic [AW-1:0]         base_i,
  output logic                  rd_en_o,
  output logic [AW-1:0]         rd_addr_o,
  input  logic [15:0]           rd_data_i,
  output logic [31:0]           hash_o,
  output logic                  done_o
);

  logic                            issue_q, issue_d;
  logic [abrcs_pkg::SAMPLES_W-1:0] idx_q, idx_d;
  logic                            vld_q, vld_d;
  logic                            last_q, last_d;
  logic                            done_q, done_d;
  logic [31:0]                     hash_q, hash_d;
  logic                            last_issue;
  logic [31:0]                     mixed;
  logic [31:0]                     product;

  assign last_issue = idx_q == (ctl_i.count - abrcs_pkg::SAMPLES_W'(1));
  assign mixed      = hash_q ^ {16'd0, rd_data_i};
  assign product    = mixed * abrcs_pkg::FNV_PRIME;

  always_comb begin
    issue_d = issue_q;
    idx_d   = idx_q;
    if (ctl_i.start) begin
      issue_d = 1'b1;
      idx_d   = '0;
    end else if (issue_q) begin
      idx_d = idx_q + abrcs_pkg::SAMPLES_W'(1);
      if (last_issue) begin
        issue_d = 1'b0;
      end
    end
    vld_d  = issue_q;
    last_d = issue_q && last_issue;
    done_d = vld_q && last_q;
    // fold one sample per cycle as read data arrives
    hash_d = vld_q ? product : hash_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      idx_q   <= '0;
      vld_q   <= 1'b0;
      last_q  <= 1'b0;
      done_q  <= 1'b0;
      hash_q  <= abrcs_pkg::FNV_BASIS;
    end else begin
      issue_q <= issue_d;
      idx_q   <= idx_d;
      vld_q   <= vld_d;
      last_q  <= last_d;
      done_q  <= done_d;
      hash_q  <= hash_d;
    end
  end

  assign rd_en_o   = issue_q;
  assign rd_addr_o = base_i + AW'(idx_q);
  assign hash_o    = hash_q;
  assign done_o    = done_q;

endmodule

[sv/abrcs_chk.sv]
`include "audio_block_ring_checksum_sink_core_defines.svh"

module abrcs_chk (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            done_o,
  input abrcs_pkg::out_t res_o
);

  // a result always leaves the block ready for the next request
  `ABRCS_ASSERT_NOW(a_done_not_busy, done_o, !busy, "result shown while busy")

  // every request either answers next cycle or starts a long pass
  `ABRCS_ASSERT_NEXT(a_req_progress, start && !busy, done_o || busy, "request dropped")

  // a full ring always has queued blocks
  `ABRCS_ASSERT_NOW(a_full_has_blocks, done_o && res_o.ring_full, res_o.queued_blocks != 4'd0,
    "full ring reported with no queued blocks")

endmodule

bind audio_block_ring_checksum_sink_core abrcs_chk u_abrcs_chk (.*);
